/* rtl/cfba_pkg.sv */
// Shared types and constants of the contiguous frame bitmap allocator.
package cfba_pkg;

   localparam int FRAME_W = 20;
   localparam int COUNT_W = 13;
   localparam int ALIGN_W = 4;
   localparam int OP_W    = 2;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLAIM = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request and set up the walk
      logic alloc_step; // one frame of the search
      logic mark_step;  // one frame of the range write
      logic mark_start; // reload the cursor for the write of an allocated run
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;
      logic search_found;
      logic mark_done;
   } sts_type;

endpackage

/* rtl/cfba_datapath.sv */
// Datapath of the allocator: bitmap memory, search cursor, range writer and counter.
module cfba_datapath import cfba_pkg::*; #(
   parameter int FRAMES    = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [FRAME_W-1:0]  csr_wdata,
   input  op_type              req_op,
   input  logic [FRAME_W-1:0]  req_first_frame,
   input  logic [COUNT_W-1:0]  req_frame_count,
   input  logic [ALIGN_W-1:0]  req_align_log2,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic [FRAME_W-1:0]  start_frame,
   output logic [COUNT_W-1:0]  free_frames,
   output logic                clear_busy
);

   localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = $clog2(FRAMES) + 2;
   localparam int CMAX      = (FRAMES < 8191) ? FRAMES : 8191;
   localparam logic [IDX_W-1:0] FRAMES_I = IDX_W'(FRAMES);

   // Whole-frame-space arithmetic is done at 22 bits.
   localparam int AW = FRAME_W + 2;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   logic [FRAME_W-1:0] base_ff;
   logic [WA_W:0]      clr_ff;
   logic [AW-1:0]      cur_ff, cur_in;       // absolute frame cursor
   logic [AW-1:0]      run_ff, run_in;       // absolute start of candidate run
   logic [COUNT_W-1:0] cnt_ff, cnt_in;       // frames still to visit
   logic [COUNT_W-1:0] len_ff;
   logic [ALIGN_W-1:0] al_ff;
   logic               used_ff;
   logic [COUNT_W-1:0] free_ff;
   logic [FRAME_W-1:0] start_ff;

   logic [AW-1:0] al_mask;
   assign al_mask = (AW'(1) << al_ff) - AW'(1);

   function automatic logic [AW-1:0] align_up(input logic [AW-1:0] x,
                                              input logic [AW-1:0] m);
      align_up = (x + m) & ~m;
   endfunction

   // Bitmap-relative index of the cursor and whether it lies in the bitmap.
   logic [AW-1:0]  rel;
   logic           in_map;
   logic [IDX_W-1:0] rel_i;
   assign rel    = cur_ff - AW'(base_ff);
   assign in_map = (cur_ff >= AW'(base_ff)) && (rel < AW'(FRAMES));
   assign rel_i  = rel[IDX_W-1:0];

   logic [WA_W-1:0]  waddr;
   logic [BIT_W-1:0] bsel;
   assign waddr = WA_W'(rel_i / IDX_W'(WORD_BITS));
   assign bsel  = BIT_W'(WORD_BITS - 1) - BIT_W'(rel_i % IDX_W'(WORD_BITS));

   // Read-modify-write of one word per frame; read data is registered first.
   logic [WORD_BITS-1:0] rd_ff;
   logic                 rd_ok_ff;   // rd_ff holds the bitmap word at rd_addr_ff
   logic [WA_W-1:0]      rd_addr_ff;

   logic frame_bit;
   assign frame_bit = rd_ff[bsel];

   logic step_active;
   assign step_active = cmd.alloc_step | cmd.mark_step;

   // Search status: done once the run is complete or the cursor has left the bitmap.
   logic past_end;
   assign past_end = (rel_i >= FRAMES_I) || (cur_ff < AW'(base_ff));
   logic found_now;
   assign found_now = (cnt_ff == '0);

   always_comb begin
      sts.search_found = 1'b0;
      sts.search_done  = 1'b0;
      if (cmd.alloc_step) begin
         if (found_now) begin
            sts.search_done  = 1'b1;
            sts.search_found = (run_ff + AW'(len_ff)) <= (AW'(1) << FRAME_W);
         end else if (!in_map || past_end) begin
            sts.search_done = 1'b1;
         end
      end
      sts.mark_done = cmd.mark_step && (cnt_ff == '0);
   end

   logic need_read;
   assign need_read = step_active && in_map && !(rd_ok_ff && rd_addr_ff == waddr);

   always_comb begin
      cur_in = cur_ff;
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cur_in = AW'(req_first_frame);
         cnt_in = req_frame_count;
         if (req_op == OP_ALLOC) begin
            cur_in = align_up(AW'(base_ff),
                              (AW'(1) << req_align_log2) - AW'(1));
         end
         run_in = cur_in;
      end else if (cmd.mark_start) begin
         cur_in = run_ff;
         cnt_in = len_ff;
      end else if (cmd.alloc_step && !found_now && in_map && !need_read) begin
         if (frame_bit) begin
            cur_in = align_up(cur_ff + AW'(1), al_mask);
            run_in = cur_in;
            cnt_in = len_ff;
         end else begin
            cur_in = cur_ff + AW'(1);
            cnt_in = cnt_ff - COUNT_W'(1);
         end
      end else if (cmd.mark_step && cnt_ff != '0 && !need_read) begin
         cur_in = cur_ff + AW'(1);
         cnt_in = cnt_ff - COUNT_W'(1);
      end
   end

   logic do_write;
   assign do_write = cmd.mark_step && cnt_ff != '0 && !need_read && in_map;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      run_ff <= run_in;
      cnt_ff <= cnt_in;
      if (cmd.load) begin
         len_ff  <= req_frame_count;
         al_ff   <= req_align_log2;
         used_ff <= (req_op != OP_FREE);
      end
      if (need_read) begin
         rd_ff      <= mem[waddr];
         rd_addr_ff <= waddr;
      end else if (do_write) begin
         rd_ff[bsel] <= used_ff;
      end
      if (do_write) begin
         mem[waddr] <= used_ff ? (rd_ff | (WORD_BITS'(1) << bsel))
                               : (rd_ff & ~(WORD_BITS'(1) << bsel));
      end else if (clear_busy) begin
         mem[clr_ff[WA_W-1:0]] <= '1;
      end
      if (sts.search_done) begin
         start_ff <= sts.search_found ? run_ff[FRAME_W-1:0] : '0;
      end else if (cmd.load) begin
         start_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         free_ff  <= '0;
         clr_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (csr_we) base_ff <= csr_wdata;
         if (clear_busy) clr_ff <= clr_ff + (WA_W+1)'(1);
         if (need_read) rd_ok_ff <= 1'b1;
         else if (cmd.load) rd_ok_ff <= 1'b0;
         if (do_write) begin
            if (used_ff) begin
               if (free_ff != '0) free_ff <= free_ff - COUNT_W'(1);
            end else if (free_ff < COUNT_W'(CMAX)) begin
               free_ff <= free_ff + COUNT_W'(1);
            end
         end
      end
   end

   assign clear_busy  = (clr_ff < (WA_W+1)'(MAP_WORDS));
   assign start_frame = start_ff;
   assign free_frames = free_ff;

endmodule

/* rtl/cfba_ctrl.sv */
// Controller of the allocator: sequences search, range write and response.
module cfba_ctrl import cfba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    clear_busy,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  op_type  req_op,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic    rsp_status,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_MARK_START, S_MARK, S_DONE
   } state_type;

   state_type state_ff;
   logic      valid_ff;
   logic      status_ff;

   logic accept;
   // In idle and after the clearing pass, a new beat is taken once the previous response has left or is leaving.
   assign req_tready = (state_ff == S_IDLE) && !clear_busy && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd = '0;
      cmd.load       = accept;
      cmd.alloc_step = (state_ff == S_SEARCH);
      cmd.mark_start = (state_ff == S_MARK_START);
      cmd.mark_step  = (state_ff == S_MARK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= 1'b0;
         status_ff <= 1'b0;
      end else begin
         if (valid_ff && rsp_tready) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  status_ff <= 1'b0;
                  case (req_op)
                     OP_ALLOC: state_ff <= S_SEARCH;
                     OP_FREE:  state_ff <= S_MARK;
                     OP_CLAIM: state_ff <= S_MARK;
                     default:  state_ff <= S_DONE;
                  endcase
               end
            end
            S_SEARCH: begin
               if (sts.search_done) begin
                  if (sts.search_found) begin
                     state_ff <= S_MARK_START;
                  end else begin
                     status_ff <= 1'b1;
                     state_ff  <= S_DONE;
                  end
               end
            end
            S_MARK_START: state_ff <= S_MARK;
            S_MARK: begin
               if (sts.mark_done) state_ff <= S_DONE;
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_status = status_ff;

endmodule

/* rtl/contiguous_frame_bitmap_allocator.sv */
// Top level of the contiguous frame bitmap allocator.
// Operation: free and claim write each frame of the range in turn, reading each bitmap word
// before its frames are written, then pass through a done state to the response. Allocate
// first searches frame by frame for a free aligned run; a found run is then reloaded and
// marked as for claim. One operation is in flight at a time; the next request beat is
// taken at the edge at which the previous response beat leaves. Synchronous reset fills
// the bitmap with used frames in a clearing pass over its ceil(FRAMES/WORD_BITS) words.
module contiguous_frame_bitmap_allocator import cfba_pkg::*; #(
   parameter int FRAMES    = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [19:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], first_frame[21:2], frame_count[34:22], align_log2[38:35], zero pad
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[0], start_frame[20:1], free_frames[33:21], zero pad
   output logic [39:0] rsp_tdata
);

   cmd_type            cmd;
   sts_type            sts;
   logic               clear_busy;
   logic               status;
   logic [FRAME_W-1:0] start_frame;
   logic [COUNT_W-1:0] free_frames;
   op_type             op;

   assign op = op_type'(req_tdata[1:0]);

   cfba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .clear_busy(clear_busy),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_op(op),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_status(status),
      .sts(sts), .cmd(cmd)
   );

   cfba_datapath #(.FRAMES(FRAMES), .WORD_BITS(WORD_BITS)) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_op(op), .req_first_frame(req_tdata[21:2]),
      .req_frame_count(req_tdata[34:22]), .req_align_log2(req_tdata[38:35]),
      .cmd(cmd), .sts(sts), .start_frame(start_frame),
      .free_frames(free_frames), .clear_busy(clear_busy)
   );

   assign rsp_tdata = {6'd0, free_frames, start_frame, status};

endmodule

/* rtl/cfba_checker.sv */
// Port-level checker for the allocator, bound to the top level.
module cfba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[20:1] == 20'd0)
      else $error("failed allocation carries a start frame");

   a_no_req_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0)
      else $error("response padding not zero");

endmodule

bind contiguous_frame_bitmap_allocator cfba_checker u_cfba_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
